### hw/rtl/closest_points_on_segments_unit_assert.svh
// Assertion macros for the closest points unit
`ifndef CLOSEST_POINTS_ON_SEGMENTS_UNIT_ASSERT_SVH
`define CLOSEST_POINTS_ON_SEGMENTS_UNIT_ASSERT_SVH

// checked outside reset
`define CPS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every edge, reset included
`define CPS_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

### hw/rtl/cps_pkg.sv
package cps_pkg;

   localparam int COORD_WIDTH = 20;
   localparam int COORD_FRAC  = 8;
   localparam int PARAM_FRAC  = 16;

   localparam int DIFF_W  = COORD_WIDTH + 1;
   localparam int PROD_W  = 2 * DIFF_W;
   localparam int SUM_W   = PROD_W + 2;
   localparam int HALF_W  = SUM_W / 2;
   localparam int MAG_W   = 2 * SUM_W;
   localparam int WIDE_W  = MAG_W + 2;
   localparam int PARAM_W = PARAM_FRAC + 1;
   localparam int OFS_W   = DIFF_W + PARAM_W + 1;
   localparam int LIMIT_W = 32;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 32'd4295;
   localparam logic [PARAM_W-1:0] PARAM_ONE   = PARAM_W'(1) << PARAM_FRAC;

   // dot product slots
   localparam int DOT_A = 0;
   localparam int DOT_B = 1;
   localparam int DOT_C = 2;
   localparam int DOT_D = 3;
   localparam int DOT_E = 4;
   localparam int NDOT  = 5;

   // wide product slots: ac, bb, be, cd, ae, bd
   localparam int PR_AC = 0;
   localparam int PR_BB = 1;
   localparam int PR_BE = 2;
   localparam int PR_CD = 3;
   localparam int PR_AE = 4;
   localparam int PR_BD = 5;
   localparam int NPROD = 6;
   localparam int PROD_X [NPROD] = '{DOT_A, DOT_B, DOT_B, DOT_C, DOT_A, DOT_B};
   localparam int PROD_Y [NPROD] = '{DOT_C, DOT_B, DOT_E, DOT_D, DOT_E, DOT_D};

   // pipeline stages
   localparam int ST_DIFF     = 0;
   localparam int ST_PROD     = 1;
   localparam int ST_SUM      = 2;
   localparam int ST_MAG      = 3;
   localparam int ST_PART     = 4;
   localparam int ST_WIDE     = 5;
   localparam int ST_COMB     = 6;
   localparam int ST_SEL      = 7;
   localparam int ST_CHK      = 8;
   localparam int ST_DIV_LAST = ST_CHK + PARAM_FRAC;
   localparam int ST_MUL      = ST_DIV_LAST + 1;
   localparam int ST_OUT      = ST_MUL + 1;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;

   typedef struct packed {
      coord_type a_start_x;
      coord_type a_start_y;
      coord_type a_start_z;
      coord_type a_end_x;
      coord_type a_end_y;
      coord_type a_end_z;
      coord_type b_start_x;
      coord_type b_start_y;
      coord_type b_start_z;
      coord_type b_end_x;
      coord_type b_end_y;
      coord_type b_end_z;
   } req_type;

   typedef struct packed {
      coord_type near_a_x;
      coord_type near_a_y;
      coord_type near_a_z;
      coord_type near_b_x;
      coord_type near_b_y;
      coord_type near_b_z;
      logic [PARAM_W-1:0] param_a;
      logic [PARAM_W-1:0] param_b;
   } rsp_type;

   typedef struct packed {
      logic [2:0][COORD_WIDTH-1:0] base_a;
      logic [2:0][DIFF_W-1:0]      dir_u;
      logic [2:0][COORD_WIDTH-1:0] base_b;
      logic [2:0][DIFF_W-1:0]      dir_v;
   } geo_type;

endpackage

### hw/rtl/closest_points_on_segments_unit.sv
// Closest points between two 3D segments, signed Q12.8 coordinates.
// req_*: one beat carries both segments (start and end of A and B).
// rsp_*: one beat per request: the point on A, the point on B and the two
//   clamped parameters in Q1.16.
// csr_*: write of the parallel limit; always ready. The user must write it
// only while idle; the block itself does not enforce this.
// New requests are taken every cycle unless a stall has filled the pipe:
// 27 register stages (dot products, split 44x44 products, 16-stage restoring
// divider per parameter, point multiply and add), each holding one item.
// Each stage advances when its downstream stage is empty or advancing, so
// a stalled rsp_ready fills the pipe from the end; req_ready drops only
// when every stage holds an item. Nothing is lost or repeated.
// Reset empties the pipeline and sets the limit to 4295.
module closest_points_on_segments_unit
   import cps_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  req_type            req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rsp_type            rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [LIMIT_W-1:0] csr_data
);

   logic [LIMIT_W-1:0] limit_ff;
   logic [ST_OUT:0]    vld_ff;
   logic [ST_OUT:0]    en;

   geo_type geo_ff [ST_DIFF:ST_MUL];
   geo_type geo_in;
   logic [DIFF_W-1:0] w_ff [3];
   logic [DIFF_W-1:0] w_in [3];

   logic signed [PROD_W-1:0] prd_ff [NDOT][3];
   logic signed [PROD_W-1:0] prd_in [NDOT][3];
   logic [SUM_W-1:0] dot_ff [ST_SUM:ST_COMB][NDOT];
   logic [SUM_W-1:0] dot_in [NDOT];
   logic [SUM_W-1:0] mag_ff [NDOT];
   logic [SUM_W-1:0] mag_in [NDOT];
   logic             neg_ff [NDOT];
   logic [2*HALF_W-1:0] pp_ff [NPROD][4];
   logic [2*HALF_W-1:0] pp_in [NPROD][4];
   logic             pneg_ff [NPROD];
   logic [WIDE_W-1:0] wide_ff [NPROD];
   logic [WIDE_W-1:0] wide_in [NPROD];
   logic [WIDE_W-1:0] dd_ff, na_ff, nb_ff;
   logic [WIDE_W-1:0] num_ff [2], den_ff [2];
   logic [WIDE_W-1:0] num_in [2], den_in [2];

   logic [WIDE_W-1:0]     rem_ff  [ST_CHK:ST_DIV_LAST][2];
   logic [WIDE_W-1:0]     rem_in  [ST_CHK:ST_DIV_LAST][2];
   logic [WIDE_W-1:0]     dv_ff   [ST_CHK:ST_DIV_LAST][2];
   logic [PARAM_FRAC-1:0] q_ff    [ST_CHK:ST_DIV_LAST][2];
   logic [PARAM_FRAC-1:0] q_in    [ST_CHK:ST_DIV_LAST][2];
   logic                  zero_ff [ST_CHK:ST_DIV_LAST][2];
   logic                  one_ff  [ST_CHK:ST_DIV_LAST][2];
   logic                  zero_in [2], one_in [2];

   logic [PARAM_W-1:0] t_ff [2];
   logic [PARAM_W-1:0] t_in [2];
   logic signed [OFS_W-1:0] ofs_ff [2][3];
   logic signed [OFS_W-1:0] ofs_in [2][3];
   rsp_type rsp_ff, rsp_in;

   // flow control
   always_comb begin
      en[ST_OUT] = !vld_ff[ST_OUT] || rsp_ready;
      for (int k = ST_OUT - 1; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
   end

   assign req_ready = en[ST_DIFF];
   assign rsp_valid = vld_ff[ST_OUT];
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff   <= '0;
         limit_ff <= LIMIT_RESET;
      end else begin
         if (csr_valid && csr_ready) begin
            limit_ff <= csr_data;
         end
         if (en[ST_DIFF]) begin
            vld_ff[ST_DIFF] <= req_valid;
         end
         for (int k = 1; k <= ST_OUT; k++) begin
            if (en[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   // stage 0: directions and start offset
   always_comb begin
      coord_type as [3], ae [3], bs [3], be [3];
      as = '{req_data.a_start_x, req_data.a_start_y, req_data.a_start_z};
      ae = '{req_data.a_end_x, req_data.a_end_y, req_data.a_end_z};
      bs = '{req_data.b_start_x, req_data.b_start_y, req_data.b_start_z};
      be = '{req_data.b_end_x, req_data.b_end_y, req_data.b_end_z};
      for (int k = 0; k < 3; k++) begin
         geo_in.base_a[k] = as[k];
         geo_in.base_b[k] = bs[k];
         geo_in.dir_u[k]  = {ae[k][COORD_WIDTH-1], ae[k]} - {as[k][COORD_WIDTH-1], as[k]};
         geo_in.dir_v[k]  = {be[k][COORD_WIDTH-1], be[k]} - {bs[k][COORD_WIDTH-1], bs[k]};
         w_in[k]          = {as[k][COORD_WIDTH-1], as[k]} - {bs[k][COORD_WIDTH-1], bs[k]};
      end
   end

   // stages 1..5: dot products, magnitudes, split products
   always_comb begin
      logic [MAG_W-1:0] m;
      logic [WIDE_W-1:0] x;
      for (int k = 0; k < 3; k++) begin
         prd_in[DOT_A][k] = $signed(geo_ff[ST_DIFF].dir_u[k]) * $signed(geo_ff[ST_DIFF].dir_u[k]);
         prd_in[DOT_B][k] = $signed(geo_ff[ST_DIFF].dir_u[k]) * $signed(geo_ff[ST_DIFF].dir_v[k]);
         prd_in[DOT_C][k] = $signed(geo_ff[ST_DIFF].dir_v[k]) * $signed(geo_ff[ST_DIFF].dir_v[k]);
         prd_in[DOT_D][k] = $signed(geo_ff[ST_DIFF].dir_u[k]) * $signed(w_ff[k]);
         prd_in[DOT_E][k] = $signed(geo_ff[ST_DIFF].dir_v[k]) * $signed(w_ff[k]);
      end
      for (int j = 0; j < NDOT; j++) begin
         dot_in[j] = SUM_W'(prd_ff[j][0]) + SUM_W'(prd_ff[j][1]) + SUM_W'(prd_ff[j][2]);
         mag_in[j] = dot_ff[ST_SUM][j][SUM_W-1] ? -dot_ff[ST_SUM][j] : dot_ff[ST_SUM][j];
      end
      for (int p = 0; p < NPROD; p++) begin
         pp_in[p][0] = mag_ff[PROD_X[p]][HALF_W-1:0] * mag_ff[PROD_Y[p]][HALF_W-1:0];
         pp_in[p][1] = mag_ff[PROD_X[p]][HALF_W-1:0] * mag_ff[PROD_Y[p]][SUM_W-1:HALF_W];
         pp_in[p][2] = mag_ff[PROD_X[p]][SUM_W-1:HALF_W] * mag_ff[PROD_Y[p]][HALF_W-1:0];
         pp_in[p][3] = mag_ff[PROD_X[p]][SUM_W-1:HALF_W] * mag_ff[PROD_Y[p]][SUM_W-1:HALF_W];
         m = MAG_W'(pp_ff[p][0]) + (MAG_W'(pp_ff[p][1]) << HALF_W)
           + (MAG_W'(pp_ff[p][2]) << HALF_W) + (MAG_W'(pp_ff[p][3]) << SUM_W);
         x = WIDE_W'(m);
         wide_in[p] = pneg_ff[p] ? -x : x;
      end
   end

   // stage 7: parallel test and divider operands
   always_comb begin
      logic par;
      logic [WIDE_W-1:0] bx, cx, dx, ex;
      bx = {{(WIDE_W-SUM_W){dot_ff[ST_COMB][DOT_B][SUM_W-1]}}, dot_ff[ST_COMB][DOT_B]};
      cx = {{(WIDE_W-SUM_W){dot_ff[ST_COMB][DOT_C][SUM_W-1]}}, dot_ff[ST_COMB][DOT_C]};
      dx = {{(WIDE_W-SUM_W){dot_ff[ST_COMB][DOT_D][SUM_W-1]}}, dot_ff[ST_COMB][DOT_D]};
      ex = {{(WIDE_W-SUM_W){dot_ff[ST_COMB][DOT_E][SUM_W-1]}}, dot_ff[ST_COMB][DOT_E]};
      par = ($signed(dd_ff) < $signed({(WIDE_W-LIMIT_W)'(0), limit_ff}))
         || ($signed(dd_ff) <= $signed(WIDE_W'(0)));
      num_in[0] = par ? '0 : na_ff;
      den_in[0] = dd_ff;
      if (!par) begin
         num_in[1] = nb_ff;
         den_in[1] = dd_ff;
      end else if ($signed(cx) < $signed(bx)) begin
         num_in[1] = dx;
         den_in[1] = bx;
      end else begin
         num_in[1] = ex;
         den_in[1] = cx;
      end
   end

   // stage 8 and divider steps
   always_comb begin
      logic [WIDE_W:0] sh;
      logic ge;
      for (int i = 0; i < 2; i++) begin
         zero_in[i] = ($signed(den_ff[i]) <= $signed(WIDE_W'(0)))
            || ($signed(num_ff[i]) <= $signed(WIDE_W'(0)));
         one_in[i]  = $signed(num_ff[i]) >= $signed(den_ff[i]);
         rem_in[ST_CHK][i] = num_ff[i];
         q_in[ST_CHK][i]   = '0;
         for (int k = ST_CHK + 1; k <= ST_DIV_LAST; k++) begin
            sh = {rem_ff[k-1][i], 1'b0};
            ge = sh >= {1'b0, dv_ff[k-1][i]};
            rem_in[k][i] = ge ? WIDE_W'(sh - {1'b0, dv_ff[k-1][i]}) : sh[WIDE_W-1:0];
            q_in[k][i]   = {q_ff[k-1][i][PARAM_FRAC-2:0], ge};
         end
         if (zero_ff[ST_DIV_LAST][i]) begin
            t_in[i] = '0;
         end else if (one_ff[ST_DIV_LAST][i]) begin
            t_in[i] = PARAM_ONE;
         end else begin
            t_in[i] = {1'b0, q_ff[ST_DIV_LAST][i]};
         end
      end
   end

   // stages 25, 26: offsets and points
   always_comb begin
      logic signed [OFS_W-1:0] s;
      for (int k = 0; k < 3; k++) begin
         ofs_in[0][k] = $signed(geo_ff[ST_DIV_LAST].dir_u[k]) * $signed({1'b0, t_in[0]});
         ofs_in[1][k] = $signed(geo_ff[ST_DIV_LAST].dir_v[k]) * $signed({1'b0, t_in[1]});
      end
      s = ofs_ff[0][0] >>> PARAM_FRAC;
      rsp_in.near_a_x = geo_ff[ST_MUL].base_a[0] + s[COORD_WIDTH-1:0];
      s = ofs_ff[0][1] >>> PARAM_FRAC;
      rsp_in.near_a_y = geo_ff[ST_MUL].base_a[1] + s[COORD_WIDTH-1:0];
      s = ofs_ff[0][2] >>> PARAM_FRAC;
      rsp_in.near_a_z = geo_ff[ST_MUL].base_a[2] + s[COORD_WIDTH-1:0];
      s = ofs_ff[1][0] >>> PARAM_FRAC;
      rsp_in.near_b_x = geo_ff[ST_MUL].base_b[0] + s[COORD_WIDTH-1:0];
      s = ofs_ff[1][1] >>> PARAM_FRAC;
      rsp_in.near_b_y = geo_ff[ST_MUL].base_b[1] + s[COORD_WIDTH-1:0];
      s = ofs_ff[1][2] >>> PARAM_FRAC;
      rsp_in.near_b_z = geo_ff[ST_MUL].base_b[2] + s[COORD_WIDTH-1:0];
      rsp_in.param_a  = t_ff[0];
      rsp_in.param_b  = t_ff[1];
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (en[ST_DIFF]) begin
         geo_ff[ST_DIFF] <= geo_in;
         w_ff            <= w_in;
      end
      for (int k = ST_DIFF + 1; k <= ST_MUL; k++) begin
         if (en[k]) begin
            geo_ff[k] <= geo_ff[k-1];
         end
      end
      if (en[ST_PROD]) begin
         prd_ff <= prd_in;
      end
      if (en[ST_SUM]) begin
         dot_ff[ST_SUM] <= dot_in;
      end
      for (int k = ST_SUM + 1; k <= ST_COMB; k++) begin
         if (en[k]) begin
            dot_ff[k] <= dot_ff[k-1];
         end
      end
      if (en[ST_MAG]) begin
         mag_ff <= mag_in;
         for (int j = 0; j < NDOT; j++) begin
            neg_ff[j] <= dot_ff[ST_SUM][j][SUM_W-1];
         end
      end
      if (en[ST_PART]) begin
         pp_ff <= pp_in;
         for (int p = 0; p < NPROD; p++) begin
            pneg_ff[p] <= neg_ff[PROD_X[p]] ^ neg_ff[PROD_Y[p]];
         end
      end
      if (en[ST_WIDE]) begin
         wide_ff <= wide_in;
      end
      if (en[ST_COMB]) begin
         dd_ff <= wide_ff[PR_AC] - wide_ff[PR_BB];
         na_ff <= wide_ff[PR_BE] - wide_ff[PR_CD];
         nb_ff <= wide_ff[PR_AE] - wide_ff[PR_BD];
      end
      if (en[ST_SEL]) begin
         num_ff <= num_in;
         den_ff <= den_in;
      end
      if (en[ST_CHK]) begin
         rem_ff[ST_CHK]  <= rem_in[ST_CHK];
         q_ff[ST_CHK]    <= q_in[ST_CHK];
         dv_ff[ST_CHK]   <= den_ff;
         zero_ff[ST_CHK] <= zero_in;
         one_ff[ST_CHK]  <= one_in;
      end
      for (int k = ST_CHK + 1; k <= ST_DIV_LAST; k++) begin
         if (en[k]) begin
            rem_ff[k]  <= rem_in[k];
            q_ff[k]    <= q_in[k];
            dv_ff[k]   <= dv_ff[k-1];
            zero_ff[k] <= zero_ff[k-1];
            one_ff[k]  <= one_ff[k-1];
         end
      end
      if (en[ST_MUL]) begin
         t_ff   <= t_in;
         ofs_ff <= ofs_in;
      end
      if (en[ST_OUT]) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

### hw/rtl/cps_checker.sv
`include "closest_points_on_segments_unit_assert.svh"

module cps_assertions
   import cps_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   `CPS_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid, "rsp_valid after reset")
   `CPS_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "rsp beat dropped or changed")
   `CPS_ASSERT(a_param_range, rsp_valid |-> rsp_data.param_a <= PARAM_ONE && rsp_data.param_b <= PARAM_ONE, "parameter above one")
   `CPS_ASSERT(a_full_only_stalled, !req_ready |-> rsp_valid && !rsp_ready, "req stalled with free output")

endmodule

bind closest_points_on_segments_unit cps_assertions u_cps_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
